// ===== hdl/tmsa_pkg.sv =====
// Package for the trimmed-mean sensor averager: sizes, constants, the class
// order table and the types used by the front end and back end; the divider uses its sizes.
// Depends on nothing.
package tmsa_pkg;

	localparam int CHANNELS = 7;
	localparam int MAX_SETS = 255;

	localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SW  = $clog2(MAX_SETS + 1);
	localparam int CLW = 3;
	localparam int MW  = 18;
	localparam int PW  = 32;
	localparam int MTW = 26;
	localparam int CTW = 40;
	localparam int AVW = 30;
	localparam int FRAC = 8;
	localparam int KW  = 10;
	localparam int DVW = SW + KW;
	localparam int DDW = CTW + FRAC;
	localparam int DCW = $clog2(DDW + 1);

	localparam int ORDER_LEN = 16;
	localparam int OJW = 4;

	localparam int FIFO_DEPTH = 2;
	localparam int FPW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FCW = $clog2(FIFO_DEPTH + 1);

	localparam logic [MW-1:0]  MASS_LOW_RESET  = '1;
	localparam logic [PW-1:0]  COUNT_LOW_RESET = 32'd4000000000;
	localparam logic [KW-1:0]  THOUSAND        = 10'd1000;
	localparam logic [AVW-1:0] AVG_MAX         = '1;

	localparam logic [OJW-1:0] CLASS_ORDER [ORDER_LEN] = '{
		4'd3, 4'd6, 4'd4, 4'd0, 4'd1, 4'd2, 4'd5, 4'd7,
		4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
	};

	function automatic logic [OJW-1:0] last_order_pos();
		logic [OJW-1:0] r;
		r = '0;
		for (int k = 0; k < ORDER_LEN; k++) begin
			if (int'(CLASS_ORDER[k]) < CHANNELS) begin
				r = OJW'(k);
			end
		end
		return r;
	endfunction

	localparam logic [OJW-1:0] LAST_J = last_order_pos();

	typedef enum logic {
		CMD_ACC,
		CMD_COLLECT
	} tmsa_cmd_t;

	typedef struct packed {
		tmsa_cmd_t      cmd;
		logic           in_range;
		logic [CLW-1:0] ch;
		logic [MW-1:0]  mass;
		logic [PW-1:0]  particles;
		logic           last_in_set;
	} tmsa_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_ERR,
		ST_LOAD,
		ST_DIV,
		ST_OUT,
		ST_CLEAR
	} tmsa_state_t;

endpackage

// ===== hdl/tmsa_front.sv =====
// Front end of the averager: accepts items, classifies them and holds them
// in a short queue for the back end. Depends on tmsa_pkg.
module tmsa_front import tmsa_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           operation,
	input  logic [CLW-1:0] channel,
	input  logic [MW-1:0]  mass,
	input  logic [PW-1:0]  particles,
	input  logic           last_in_set,
	output tmsa_item_t     head,
	output logic           head_valid,
	input  logic           pop
);

	tmsa_item_t     fifo_q [FIFO_DEPTH];
	logic [FPW-1:0] wr_ptr_q;
	logic [FPW-1:0] rd_ptr_q;
	logic [FCW-1:0] cnt_q;
	tmsa_item_t     item;
	logic           push;
	logic           do_pop;

	always_comb begin
		item.cmd         = operation ? CMD_COLLECT : CMD_ACC;
		item.in_range    = int'(channel) < CHANNELS;
		item.ch          = channel;
		item.mass        = mass;
		item.particles   = particles;
		item.last_in_set = last_in_set;
	end

	assign in_ready   = cnt_q != FCW'(FIFO_DEPTH);
	assign push       = in_valid && in_ready;
	assign head_valid = cnt_q != '0;
	assign head       = fifo_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FPW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == FPW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/tmsa_div.sv =====
// Bit-serial restoring divider used for every average, one quotient bit
// per cycle. Depends on tmsa_pkg.
module tmsa_div import tmsa_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [DDW-1:0] dividend,
	input  logic [DVW-1:0] divisor,
	output logic           busy,
	output logic [DDW-1:0] quotient
);

	logic           busy_q;
	logic [DCW-1:0] cnt_q;
	logic [DDW-1:0] quo_q;
	logic [DVW-1:0] rem_q;
	logic [DVW-1:0] dvs_q;
	logic [DVW:0]   trial;
	logic [DVW:0]   diff;
	logic           ge;

	assign trial    = {rem_q, quo_q[DDW-1]};
	assign diff     = trial - {1'b0, dvs_q};
	assign ge       = trial >= {1'b0, dvs_q};
	assign busy     = busy_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DDW-2:0], ge};
			rem_q <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DCW'(DDW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DCW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hdl/tmsa_back.sv =====
// Back end of the averager: per-class accumulators, the collect sequencer
// and the result register. Depends on tmsa_pkg and tmsa_div.
module tmsa_back import tmsa_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  tmsa_item_t     head,
	input  logic           head_valid,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           kind,
	output logic [CLW-1:0] class_index,
	output logic [AVW-1:0] average,
	output logic           status,
	output logic           last
);

	logic [MTW-1:0] mass_total_q  [CHANNELS];
	logic [MW-1:0]  mass_low_q    [CHANNELS];
	logic [MW-1:0]  mass_high_q   [CHANNELS];
	logic [CTW-1:0] count_total_q [CHANNELS];
	logic [PW-1:0]  count_low_q   [CHANNELS];
	logic [PW-1:0]  count_high_q  [CHANNELS];
	logic [SW-1:0]  sets_q;

	tmsa_state_t    state_q;
	tmsa_state_t    state_next;
	logic           pass_q;
	logic [OJW-1:0] j_q;
	logic [SW-1:0]  n_q;
	logic [DVW-1:0] n1000_q;
	logic           trim_q;

	logic           out_valid_q;
	logic           kind_q;
	logic [CLW-1:0] class_q;
	logic [AVW-1:0] avg_q;
	logic           status_q;
	logic           last_q;

	logic           acc_en;
	logic           acc_write;
	logic           prep_en;
	logic           err_load;
	logic           res_load;
	logic           j_step;
	logic           pass_flip;
	logic           div_start;
	logic           clr;
	logic           out_free;
	logic           class_ok;
	logic           is_last_j;

	logic [CIW-1:0] addr;
	logic [MTW-1:0] rd_mt;
	logic [MW-1:0]  rd_ml;
	logic [MW-1:0]  rd_mh;
	logic [CTW-1:0] rd_ct;
	logic [PW-1:0]  rd_cl;
	logic [PW-1:0]  rd_ch;

	logic [MTW:0]   mt_sum;
	logic [CTW:0]   ct_sum;
	logic [MTW-1:0] mt_new;
	logic [CTW-1:0] ct_new;

	logic [SW-1:0]  n_c;
	logic [DVW-1:0] n1000_c;
	logic [MW:0]    m_drop;
	logic [PW:0]    c_drop;
	logic [MTW-1:0] m_trim;
	logic [CTW-1:0] c_trim;
	logic [DDW-1:0] dividend;
	logic [DVW-1:0] divisor;
	logic           div_busy;
	logic [DDW-1:0] quotient;
	logic [AVW-1:0] avg_sat;

	assign out_free  = !out_valid_q || out_ready;
	assign class_ok  = int'(CLASS_ORDER[j_q]) < CHANNELS;
	assign is_last_j = j_q == LAST_J;

	assign addr  = (state_q == ST_IDLE) ? CIW'(head.ch) : CIW'(CLASS_ORDER[j_q]);
	assign rd_mt = mass_total_q[addr];
	assign rd_ml = mass_low_q[addr];
	assign rd_mh = mass_high_q[addr];
	assign rd_ct = count_total_q[addr];
	assign rd_cl = count_low_q[addr];
	assign rd_ch = count_high_q[addr];

	assign mt_sum = {1'b0, rd_mt} + (MTW + 1)'(head.mass);
	assign ct_sum = {1'b0, rd_ct} + (CTW + 1)'(head.particles);
	assign mt_new = mt_sum[MTW] ? '1 : mt_sum[MTW-1:0];
	assign ct_new = ct_sum[CTW] ? '1 : ct_sum[CTW-1:0];

	assign n_c     = (sets_q > SW'(2)) ? sets_q - SW'(2) : sets_q;
	assign n1000_c = DVW'(n_c) * DVW'(THOUSAND);

	always_comb begin
		m_drop = (MW + 1)'(rd_ml) + (MW + 1)'(rd_mh);
		c_drop = (PW + 1)'(rd_cl) + (PW + 1)'(rd_ch);
		if (!trim_q) begin
			m_trim = rd_mt;
		end else if (rd_mt > MTW'(m_drop)) begin
			m_trim = rd_mt - MTW'(m_drop);
		end else begin
			m_trim = '0;
		end
		if (!trim_q) begin
			c_trim = rd_ct;
		end else if (rd_ct > CTW'(c_drop)) begin
			c_trim = rd_ct - CTW'(c_drop);
		end else begin
			c_trim = '0;
		end
		dividend = pass_q ? {c_trim, {FRAC{1'b0}}} : DDW'(m_trim);
		divisor  = pass_q ? n1000_q : DVW'(n_q);
	end

	assign avg_sat = (|quotient[DDW-1:AVW]) ? AVG_MAX : quotient[AVW-1:0];

	tmsa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.busy     (div_busy),
		.quotient (quotient)
	);

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (head_valid && head.cmd == CMD_COLLECT) begin
					state_next = ST_PREP;
				end
			end
			ST_PREP: begin
				state_next = (sets_q == '0) ? ST_ERR : ST_LOAD;
			end
			ST_ERR: begin
				if (out_free) begin
					state_next = ST_CLEAR;
				end
			end
			ST_LOAD: begin
				if (class_ok) begin
					state_next = ST_DIV;
				end
			end
			ST_DIV: begin
				if (!div_busy) begin
					state_next = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_next = (is_last_j && pass_q) ? ST_CLEAR : ST_LOAD;
				end
			end
			ST_CLEAR: begin
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		acc_en    = 1'b0;
		prep_en   = 1'b0;
		err_load  = 1'b0;
		res_load  = 1'b0;
		j_step    = 1'b0;
		pass_flip = 1'b0;
		div_start = 1'b0;
		clr       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				pop    = head_valid;
				acc_en = head_valid && head.cmd == CMD_ACC && int'(sets_q) < MAX_SETS;
			end
			ST_PREP: begin
				prep_en = 1'b1;
			end
			ST_ERR: begin
				err_load = out_free;
			end
			ST_LOAD: begin
				div_start = class_ok;
				j_step    = !class_ok;
			end
			ST_OUT: begin
				res_load  = out_free;
				j_step    = out_free && !is_last_j;
				pass_flip = out_free && is_last_j && !pass_q;
			end
			ST_CLEAR: begin
				clr = 1'b1;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	assign acc_write = acc_en && head.in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q  <= 1'b0;
			j_q     <= '0;
			n_q     <= '0;
			n1000_q <= '0;
			trim_q  <= 1'b0;
		end else begin
			state_q <= state_next;
			if (prep_en) begin
				pass_q  <= 1'b0;
				j_q     <= '0;
				n_q     <= n_c;
				n1000_q <= n1000_c;
				trim_q  <= sets_q > SW'(2);
			end else if (pass_flip) begin
				pass_q <= 1'b1;
				j_q    <= '0;
			end else if (j_step) begin
				j_q <= j_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sets_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				mass_total_q[i]  <= '0;
				mass_low_q[i]    <= MASS_LOW_RESET;
				mass_high_q[i]   <= '0;
				count_total_q[i] <= '0;
				count_low_q[i]   <= COUNT_LOW_RESET;
				count_high_q[i]  <= '0;
			end
		end else if (clr) begin
			sets_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				mass_total_q[i]  <= '0;
				mass_low_q[i]    <= MASS_LOW_RESET;
				mass_high_q[i]   <= '0;
				count_total_q[i] <= '0;
				count_low_q[i]   <= COUNT_LOW_RESET;
				count_high_q[i]  <= '0;
			end
		end else begin
			if (acc_en && head.last_in_set) begin
				sets_q <= sets_q + 1'b1;
			end
			for (int i = 0; i < CHANNELS; i++) begin
				if (acc_write && addr == CIW'(i)) begin
					mass_total_q[i]  <= mt_new;
					count_total_q[i] <= ct_new;
					if (head.mass < rd_ml) begin
						mass_low_q[i] <= head.mass;
					end
					if (head.mass > rd_mh) begin
						mass_high_q[i] <= head.mass;
					end
					if (head.particles < rd_cl) begin
						count_low_q[i] <= head.particles;
					end
					if (head.particles > rd_ch) begin
						count_high_q[i] <= head.particles;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (err_load) begin
			kind_q   <= 1'b0;
			class_q  <= '0;
			avg_q    <= '0;
			status_q <= 1'b1;
			last_q   <= 1'b1;
		end else if (res_load) begin
			kind_q   <= pass_q;
			class_q  <= CLW'(CLASS_ORDER[j_q]);
			avg_q    <= avg_sat;
			status_q <= 1'b0;
			last_q   <= pass_q && is_last_j;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (err_load || res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign class_index = class_q;
	assign average     = avg_q;
	assign status      = status_q;
	assign last        = last_q;

endmodule

// ===== hdl/trimmed_mean_sensor_averager_core.sv =====
// An accumulate item passes through the input queue and, when the back end is idle,
// updates its class accumulators as it is popped, so accumulate items flow at one
// per cycle while no collect is in progress. A collect item produces 14 results,
// each from the 48-step bit-serial divider, or one error result if no set was recorded.
// Reset clears all accumulators, the set count, the input queue and the result valid flag.
// Top level of the averager. Depends on tmsa_pkg, tmsa_front and tmsa_back.
module trimmed_mean_sensor_averager_core import tmsa_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           operation,
	input  logic [CLW-1:0] channel,
	input  logic [MW-1:0]  mass,
	input  logic [PW-1:0]  particles,
	input  logic           last_in_set,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           kind,
	output logic [CLW-1:0] class_index,
	output logic [AVW-1:0] average,
	output logic           status,
	output logic           last
);

	tmsa_item_t head;
	logic       head_valid;
	logic       pop;

	tmsa_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.channel     (channel),
		.mass        (mass),
		.particles   (particles),
		.last_in_set (last_in_set),
		.head        (head),
		.head_valid  (head_valid),
		.pop         (pop)
	);

	tmsa_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (head_valid),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.class_index (class_index),
		.average     (average),
		.status      (status),
		.last        (last)
	);

endmodule

// ===== dv/trimmed_mean_sensor_averager_core_test.sv =====
`timescale 1ns / 1ps
// Testbench for trimmed_mean_sensor_averager_core. It sends accumulate and collect
// items with random pacing and checks each average against a predictor kept here.
// Depends on tmsa_pkg and the core RTL.
module trimmed_mean_sensor_averager_core_test;
	import tmsa_pkg::*;

	localparam int MASS_SUM_W = 26;
	localparam int COUNT_SUM_W = 40;
	localparam int FRACTION_BITS = 8;
	localparam int PER_THOUSAND = 1000;
	localparam logic [63:0] MASS_SUM_MAX = (64'd1 << MASS_SUM_W) - 64'd1;
	localparam logic [63:0] COUNT_SUM_MAX = (64'd1 << COUNT_SUM_W) - 64'd1;
	localparam logic [63:0] AVERAGE_MAX = (64'd1 << AVW) - 64'd1;
	localparam logic [MW-1:0] MASS_ALL_ONES = '1;
	localparam logic [PW-1:0] COUNT_CEILING = 32'd4000000000;
	localparam logic [CLW-1:0] SPARE_CLASS = CLW'(CHANNELS);
	localparam logic KIND_MASS = 1'b0;
	localparam logic KIND_COUNT = 1'b1;
	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;
	localparam int COLLECT_ORDER [7] = '{3, 6, 4, 0, 1, 2, 5};
	localparam int RANDOM_ITEMS = 110;
	localparam int SETTLE_CYCLES = 60;
	localparam int RUN_LIMIT = 1000000;
	localparam int REPORT_LINES = 40;

	typedef struct packed {
		logic           kind;
		logic [CLW-1:0] class_index;
		logic [AVW-1:0] average;
		logic           status;
		logic           last;
	} average_rec_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           in_valid = 1'b0;
	logic           in_ready;
	logic           operation = 1'b0;
	logic [CLW-1:0] channel = '0;
	logic [MW-1:0]  mass = '0;
	logic [PW-1:0]  particles = '0;
	logic           last_in_set = 1'b0;
	logic           out_valid;
	logic           out_ready = 1'b0;
	logic           kind;
	logic [CLW-1:0] class_index;
	logic [AVW-1:0] average;
	logic           status;
	logic           last;

	logic [63:0] mass_sum [CHANNELS];
	logic [63:0] mass_min [CHANNELS];
	logic [63:0] mass_max [CHANNELS];
	logic [63:0] count_sum [CHANNELS];
	logic [63:0] count_min [CHANNELS];
	logic [63:0] count_max [CHANNELS];
	int sets_done;
	average_rec_t expected_averages [$];

	int errors = 0;
	int results_seen = 0;
	int unsigned cycle_count = 0;
	bit steady = 1'b0;
	int hold_left = 0;
	int rx_roll;

	trimmed_mean_sensor_averager_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.channel(channel),
		.mass(mass),
		.particles(particles),
		.last_in_set(last_in_set),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.class_index(class_index),
		.average(average),
		.status(status),
		.last(last)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("[trimmed_mean_sensor_averager_core] ERROR");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (steady) begin
			out_ready <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			rx_roll = $urandom_range(0, 99);
			if (rx_roll < 70) begin
				out_ready <= 1'b1;
			end else if (rx_roll < 95) begin
				out_ready <= 1'b0;
				hold_left <= $urandom_range(0, 3);
			end else begin
				out_ready <= 1'b0;
				hold_left <= $urandom_range(10, 40);
			end
		end
	end

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= REPORT_LINES) begin
			$display("mismatch at result %0d: %s", results_seen, msg);
		end
	endtask

	always @(posedge clk) begin
		average_rec_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_averages.size() == 0) begin
				report_mismatch("result arrived with nothing expected");
			end else begin
				want = expected_averages.pop_front();
				if (kind !== want.kind)
					report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
				if (class_index !== want.class_index)
					report_mismatch($sformatf("class_index %0d, expected %0d",
						class_index, want.class_index));
				if (average !== want.average)
					report_mismatch($sformatf("average %0d, expected %0d (class %0d kind %0d)",
						average, want.average, want.class_index, want.kind));
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
				if (last !== want.last)
					report_mismatch($sformatf("last %0d, expected %0d", last, want.last));
			end
			results_seen++;
		end
	end

	function automatic void clear_accumulators();
		for (int c = 0; c < CHANNELS; c++) begin
			mass_sum[c] = '0;
			mass_min[c] = 64'(MASS_ALL_ONES);
			mass_max[c] = '0;
			count_sum[c] = '0;
			count_min[c] = 64'(COUNT_CEILING);
			count_max[c] = '0;
		end
		sets_done = 0;
	endfunction

	function automatic logic [63:0] trimmed_sum(input logic [63:0] total, input logic [63:0] lo,
			input logic [63:0] hi, input logic trim_on);
		if (!trim_on)
			return total;
		return (total > lo + hi) ? total - lo - hi : 64'd0;
	endfunction

	function automatic void accumulate_sample(input int ch, input logic [63:0] m,
			input logic [63:0] p, input logic lis);
		if (sets_done >= MAX_SETS)
			return;
		if (ch < CHANNELS) begin
			mass_sum[ch] = (mass_sum[ch] + m > MASS_SUM_MAX) ? MASS_SUM_MAX : mass_sum[ch] + m;
			count_sum[ch] = (count_sum[ch] + p > COUNT_SUM_MAX) ? COUNT_SUM_MAX : count_sum[ch] + p;
			if (m < mass_min[ch]) mass_min[ch] = m;
			if (m > mass_max[ch]) mass_max[ch] = m;
			if (p < count_min[ch]) count_min[ch] = p;
			if (p > count_max[ch]) count_max[ch] = p;
		end
		if (lis)
			sets_done++;
	endfunction

	function automatic void collect_averages();
		average_rec_t rec;
		logic trim_on;
		logic [63:0] divisor;
		logic [63:0] value;
		int c;
		int k;
		rec = '0;
		if (sets_done == 0) begin
			rec.kind = KIND_MASS;
			rec.status = STATUS_EMPTY;
			rec.last = 1'b1;
			expected_averages.push_back(rec);
			clear_accumulators();
			return;
		end
		trim_on = sets_done > 2;
		divisor = trim_on ? 64'(sets_done - 2) : 64'(sets_done);
		k = 0;
		for (int half = 0; half < 2; half++) begin
			for (int j = 0; j < 7; j++) begin
				c = COLLECT_ORDER[j];
				if (c >= CHANNELS)
					continue;
				if (half == 0)
					value = trimmed_sum(mass_sum[c], mass_min[c], mass_max[c], trim_on) / divisor;
				else
					value = (trimmed_sum(count_sum[c], count_min[c], count_max[c], trim_on)
						<< FRACTION_BITS) / (divisor * PER_THOUSAND);
				rec.kind = (half == 0) ? KIND_MASS : KIND_COUNT;
				rec.class_index = CLW'(c);
				rec.average = AVW'((value > AVERAGE_MAX) ? AVERAGE_MAX : value);
				rec.status = STATUS_OK;
				rec.last = (k == 2 * CHANNELS - 1);
				expected_averages.push_back(rec);
				k++;
			end
		end
		clear_accumulators();
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [MW-1:0] random_mass();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return MASS_ALL_ONES;
			2: return MW'(256000);
			default: return MW'($urandom);
		endcase
	endfunction

	function automatic logic [PW-1:0] random_count();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return COUNT_CEILING;
			default: return $urandom;
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance with
	// in_valid still high, so the next item can follow without a gap.
	task automatic send_item(input tmsa_cmd_t op, input logic [CLW-1:0] ch,
			input logic [MW-1:0] m, input logic [PW-1:0] p, input logic lis);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		channel <= ch;
		mass <= m;
		particles <= p;
		last_in_set <= lis;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (op == CMD_COLLECT)
			collect_averages();
		else
			accumulate_sample(int'(ch), 64'(m), 64'(p), lis);
		@(negedge clk);
	endtask

	task automatic send_sample(input logic [CLW-1:0] ch, input logic [MW-1:0] m,
			input logic [PW-1:0] p, input logic lis);
		send_item(CMD_ACC, ch, m, p, lis);
	endtask

	task automatic send_collect();
		send_item(CMD_COLLECT, CLW'($urandom), random_mass(), random_count(), 1'($urandom));
	endtask

	task automatic test_empty_collect();
		send_collect();
		for (int c = 0; c < CHANNELS; c += 3)
			send_sample(CLW'(c), random_mass(), random_count(), 1'b0);
		send_collect();
		send_sample(CLW'(4), MW'(1000), 32'd5000, 1'b1);
		send_collect();
	endtask

	task automatic test_two_sets_extremes();
		for (int c = 0; c < CHANNELS; c++)
			send_sample(CLW'(c), MASS_ALL_ONES, '1, c == CHANNELS - 1);
		for (int c = 0; c < CHANNELS - 1; c++)
			send_sample(CLW'(c), '0, '0, 1'b0);
		send_sample(SPARE_CLASS, MASS_ALL_ONES, '1, 1'b1);
		send_collect();
	endtask

	task automatic test_trimmed_sets();
		for (int s = 0; s < 3; s++) begin
			for (int c = 0; c < CHANNELS; c++) begin
				if (c != 2)
					send_sample(CLW'(c), random_mass(), random_count(), c == CHANNELS - 1);
			end
		end
		send_collect();
	endtask

	// The two leading items carry no set mark, so both sums saturate by the time
	// the set count fills.
	task automatic test_saturation_and_full_sets();
		steady = 1'b1;
		for (int i = 0; i < MAX_SETS + 2; i++)
			send_sample(CLW'(5), MASS_ALL_ONES, '1, i >= 2);
		steady = 1'b0;
		send_sample(CLW'(0), MASS_ALL_ONES, '1, 1'b1);
		send_sample(CLW'(3), '0, '0, 1'b0);
		send_sample(SPARE_CLASS, MASS_ALL_ONES, '1, 1'b1);
		send_collect();
		send_sample(CLW'(6), random_mass(), random_count(), 1'b1);
		send_collect();
	endtask

	task automatic test_random_sessions();
		int sent;
		int sets;
		int swap_at;
		int tmp;
		int order [CHANNELS];
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			steady = ($urandom_range(0, 3) == 0);
			sets = $urandom_range(0, 6);
			for (int s = 0; s < sets; s++) begin
				for (int c = 0; c < CHANNELS; c++)
					order[c] = c;
				for (int c = CHANNELS - 1; c > 0; c--) begin
					swap_at = $urandom_range(0, c);
					tmp = order[c];
					order[c] = order[swap_at];
					order[swap_at] = tmp;
				end
				for (int c = 0; c < CHANNELS; c++) begin
					if ($urandom_range(0, 11) == 0) begin
						send_sample(CLW'($urandom), random_mass(), random_count(), 1'($urandom));
						sent++;
					end
					if (c == CHANNELS - 1 || $urandom_range(0, 9) != 0) begin
						send_sample(CLW'(order[c]), random_mass(), random_count(),
							c == CHANNELS - 1);
						sent++;
					end
				end
			end
			send_collect();
			sent++;
		end
		steady = 1'b0;
	endtask

	initial begin
		clear_accumulators();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		test_empty_collect();
		test_two_sets_extremes();
		test_trimmed_sets();
		test_saturation_and_full_sets();
		test_random_sessions();
		in_valid <= 1'b0;
		while (expected_averages.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("[trimmed_mean_sensor_averager_core] OK");
		else
			$display("[trimmed_mean_sensor_averager_core] ERROR");
		$finish;
	end

endmodule
